// File: design/modinv_pkg.sv
// Shared constants and the microcode program of the modular inverse block.
// No dependencies; imported by design/modular_inverse_extgcd.sv and sim/modular_inverse_extgcd_tb.sv.
package modinv_pkg;

  localparam int MODINV_WIDTH = 30;
  localparam logic [63:0] MODULUS_RESET = 64'd1000000007;

  // Microcode sequencing.
  localparam int PC_W = 3;

  localparam logic [PC_W-1:0] PC_WAIT   = 3'd0;
  localparam logic [PC_W-1:0] PC_TEST   = 3'd1;
  localparam logic [PC_W-1:0] PC_DIV    = 3'd2;
  localparam logic [PC_W-1:0] PC_UPDATE = 3'd3;
  localparam logic [PC_W-1:0] PC_EMIT   = 3'd4;

  localparam logic [2:0] OP_LOAD    = 3'd0;
  localparam logic [2:0] OP_DIVINIT = 3'd1;
  localparam logic [2:0] OP_DIVSTEP = 3'd2;
  localparam logic [2:0] OP_UPDATE  = 3'd3;
  localparam logic [2:0] OP_EMIT    = 3'd4;

  localparam logic [2:0] C_ALWAYS   = 3'd0;
  localparam logic [2:0] C_IN_VALID = 3'd1;
  localparam logic [2:0] C_R_ZERO   = 3'd2;
  localparam logic [2:0] C_CNT_DONE = 3'd3;
  localparam logic [2:0] C_OUT_FREE = 3'd4;

  typedef struct packed {
    logic [2:0]      op;
    logic [2:0]      cond;
    logic [PC_W-1:0] jmp_t;  // taken when the condition holds
    logic [PC_W-1:0] jmp_f;  // taken otherwise
  } uword_t;

  // Control store: one word per step of the extended Euclidean loop.
  function automatic uword_t ucode_rom(input logic [PC_W-1:0] pc);
    uword_t w;
    case (pc)
      PC_WAIT:   w = '{op: OP_LOAD,    cond: C_IN_VALID, jmp_t: PC_TEST,   jmp_f: PC_WAIT};
      PC_TEST:   w = '{op: OP_DIVINIT, cond: C_R_ZERO,   jmp_t: PC_EMIT,   jmp_f: PC_DIV};
      PC_DIV:    w = '{op: OP_DIVSTEP, cond: C_CNT_DONE, jmp_t: PC_UPDATE, jmp_f: PC_DIV};
      PC_UPDATE: w = '{op: OP_UPDATE,  cond: C_ALWAYS,   jmp_t: PC_TEST,   jmp_f: PC_TEST};
      PC_EMIT:   w = '{op: OP_EMIT,    cond: C_OUT_FREE, jmp_t: PC_WAIT,   jmp_f: PC_EMIT};
      default:   w = '{op: OP_EMIT,    cond: C_ALWAYS,   jmp_t: PC_WAIT,   jmp_f: PC_WAIT};
    endcase
    return w;
  endfunction

endpackage

// File: design/modular_inverse_extgcd.sv
// Per item, the sequencer takes the input transfer and then runs n quotient steps (n = number
// of quotient steps, up to about 44 for 30-bit operands); each step is a test, a bit-serial
// division that forms one quotient bit per division step, and an update; a final test leads to the emit step.
// The block works on one item at a time; the emit step waits while the output register
// holds a result not yet taken, and the next transfer can be taken as soon as the result
// is placed in the output register, even while that result still waits to be taken.
// Reset (rst_n, synchronous, active low) returns the sequencer to its wait step, drops
// the output valid and loads the modulus register with 1000000007.
//
// Modular inverse by the extended Euclidean algorithm, microcoded.
// Depends on design/modinv_pkg.sv.
module modular_inverse_extgcd #(
  parameter int WIDTH = modinv_pkg::MODINV_WIDTH
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // Configuration write channel: modulus.
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [WIDTH-1:0]                 cfg_data,
  // Input stream. in_tdata: value [WIDTH-1:0], zero padding above.
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [((WIDTH+7)/8)*8-1:0]       in_tdata,
  // Result stream. out_tdata: inverse [WIDTH-1:0], common_divisor [2*WIDTH-1:WIDTH],
  // zero padding above.
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [((2*WIDTH+7)/8)*8-1:0]     out_tdata
);
  import modinv_pkg::*;

  // Coefficients stay within the modulus in magnitude; two extra bits hold the sign
  // and the intermediate product old_s - q*s, which is formed modulo 2^CW.
  localparam int CW   = WIDTH + 2;
  localparam int CNTW = (WIDTH > 1) ? $clog2(WIDTH) : 1;
  localparam int OUTW = ((2*WIDTH+7)/8)*8;

  logic [WIDTH-1:0] mod_r,   mod_nxt;
  logic [PC_W-1:0]  pc_r,    pc_nxt;
  logic [WIDTH-1:0] old_r_r, old_r_nxt;
  logic [WIDTH-1:0] r_r,     r_nxt;
  logic [CW-1:0]    old_s_r, old_s_nxt;
  logic [CW-1:0]    s_r,     s_nxt;
  logic [WIDTH-1:0] dvd_r,   dvd_nxt;
  logic [WIDTH-1:0] rem_r,   rem_nxt;
  logic [CW-1:0]    acc_r,   acc_nxt;
  logic [CNTW-1:0]  cnt_r,   cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [WIDTH-1:0] out_inv_r,   out_inv_nxt;
  logic [WIDTH-1:0] out_gcd_r,   out_gcd_nxt;

  uword_t           uw;
  logic             cond_ok;
  logic             out_free;
  logic [WIDTH:0]   rem_sh;
  logic             q_bit;
  logic [WIDTH:0]   rem_diff;
  logic             coef_neg;
  logic [CW-1:0]    coef_mag;
  logic [WIDTH-1:0] mag_w;
  logic [WIDTH-1:0] mag_red;
  logic [WIDTH-1:0] inv_val;

  assign uw        = ucode_rom(pc_r);
  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = (uw.op == OP_LOAD);
  assign cfg_ready = 1'b1;

  always_comb begin
    case (uw.cond)
      C_ALWAYS:   cond_ok = 1'b1;
      C_IN_VALID: cond_ok = in_tvalid;
      C_R_ZERO:   cond_ok = (r_r == '0);
      C_CNT_DONE: cond_ok = (cnt_r == '0);
      C_OUT_FREE: cond_ok = out_free;
      default:    cond_ok = 1'b1;
    endcase
  end

  // One restoring division step: shift the next dividend bit into the remainder.
  assign rem_sh   = {rem_r, dvd_r[WIDTH-1]};
  assign q_bit    = (rem_sh >= {1'b0, r_r});
  assign rem_diff = rem_sh - {1'b0, r_r};

  // Final reduction of the signed Bezout coefficient into 0..modulus-1. Its magnitude
  // never exceeds the modulus, so one compare-and-subtract is enough.
  assign coef_neg = old_s_r[CW-1];
  assign coef_mag = coef_neg ? (~old_s_r + CW'(1)) : old_s_r;
  assign mag_w    = coef_mag[WIDTH-1:0];
  assign mag_red  = (mag_w >= mod_r) ? (mag_w - mod_r) : mag_w;

  always_comb begin
    if (mod_r == '0) begin
      inv_val = '0;
    end else if (coef_neg && (mag_red != '0)) begin
      inv_val = mod_r - mag_red;
    end else begin
      inv_val = mag_red;
    end
  end

  always_comb begin
    mod_nxt       = mod_r;
    pc_nxt        = cond_ok ? uw.jmp_t : uw.jmp_f;
    old_r_nxt     = old_r_r;
    r_nxt         = r_r;
    old_s_nxt     = old_s_r;
    s_nxt         = s_r;
    dvd_nxt       = dvd_r;
    rem_nxt       = rem_r;
    acc_nxt       = acc_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_inv_nxt   = out_inv_r;
    out_gcd_nxt   = out_gcd_r;

    if (cfg_valid) begin
      mod_nxt = cfg_data;
    end

    case (uw.op)
      OP_LOAD: begin
        if (in_tvalid) begin
          old_r_nxt = in_tdata[WIDTH-1:0];
          r_nxt     = mod_r;
          old_s_nxt = CW'(1);
          s_nxt     = '0;
        end
      end
      OP_DIVINIT: begin
        dvd_nxt = old_r_r;
        rem_nxt = '0;
        acc_nxt = '0;
        cnt_nxt = CNTW'(WIDTH - 1);
      end
      OP_DIVSTEP: begin
        // Quotient bits arrive MSB first, so q*s builds up by shift and add.
        dvd_nxt = {dvd_r[WIDTH-2:0], 1'b0};
        rem_nxt = q_bit ? rem_diff[WIDTH-1:0] : rem_sh[WIDTH-1:0];
        acc_nxt = {acc_r[CW-2:0], 1'b0} + (q_bit ? s_r : '0);
        cnt_nxt = cnt_r - CNTW'(1);
      end
      OP_UPDATE: begin
        old_r_nxt = r_r;
        r_nxt     = rem_r;
        old_s_nxt = s_r;
        s_nxt     = old_s_r - acc_r;
      end
      OP_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_inv_nxt   = inv_val;
          out_gcd_nxt   = old_r_r;
        end
      end
      default: begin
        pc_nxt = PC_WAIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mod_r       <= MODULUS_RESET[WIDTH-1:0];
      pc_r        <= PC_WAIT;
      out_valid_r <= 1'b0;
    end else begin
      mod_r       <= mod_nxt;
      pc_r        <= pc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    old_r_r   <= old_r_nxt;
    r_r       <= r_nxt;
    old_s_r   <= old_s_nxt;
    s_r       <= s_nxt;
    dvd_r     <= dvd_nxt;
    rem_r     <= rem_nxt;
    acc_r     <= acc_nxt;
    cnt_r     <= cnt_nxt;
    out_inv_r <= out_inv_nxt;
    out_gcd_r <= out_gcd_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUTW'({out_gcd_r, out_inv_r});

`ifndef SYNTHESIS
  // The divider only runs with a nonzero divisor.
  assert property (@(posedge clk) disable iff (!rst_n)
    (pc_r == PC_DIV) |-> (r_r != '0))
    else $error("division step entered with zero divisor");

  // The partial remainder always stays below the divisor.
  assert property (@(posedge clk) disable iff (!rst_n)
    (pc_r == PC_DIV) |-> (rem_r < r_r))
    else $error("partial remainder not below divisor");

  // A new result appears only out of the emit step.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !$past(out_tvalid && !out_tready)) |-> $past(pc_r == PC_EMIT))
    else $error("result raised outside the emit step");

  // An accepted input always starts the quotient loop.
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (pc_r == PC_TEST))
    else $error("accepted input did not start the loop");

  // The reduced inverse is below a nonzero modulus.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (mod_r != '0)) |-> (out_inv_r < mod_r))
    else $error("inverse not reduced below modulus");
`endif

endmodule

// File: sim/modular_inverse_extgcd_tb.sv
// Self-checking testbench for modular_inverse_extgcd: drives values and modulus writes,
// predicts each inverse and gcd with its own extended Euclid, and checks every transfer.
// Depends on design/modinv_pkg.sv and design/modular_inverse_extgcd.sv.
module modular_inverse_extgcd_tb;
  import modinv_pkg::*;

  localparam int W = MODINV_WIDTH;
  localparam int IN_BITS = ((W + 7) / 8) * 8;
  localparam int OUT_BITS = ((2 * W + 7) / 8) * 8;
  localparam logic [W-1:0] MOD_MAX = '1;
  localparam logic [W-1:0] MOD_PRIME = MODULUS_RESET[W-1:0];
  // Consecutive Fibonacci numbers give the longest quotient chain that fits.
  localparam logic [W-1:0] FIB_44 = 30'd701408733;
  localparam logic [W-1:0] FIB_43 = 30'd433494437;
  localparam int RANDOM_PHASES = 12;
  localparam int ITEMS_PER_PHASE = 96;
  localparam int STALL_LIMIT = 20000;
  localparam int SETTLE_CYCLES = 3 + 44 * (W + 2) + 100;
  localparam int REPORT_LIMIT = 10;
  localparam int DIRECTED_ITEMS = 23;

  // Directed items, grouped by modulus; the first group runs on the reset modulus.
  localparam logic [W-1:0] DIR_MOD [DIRECTED_ITEMS] = '{
    MOD_PRIME, MOD_PRIME, MOD_PRIME, MOD_PRIME, MOD_PRIME,
    MOD_PRIME, MOD_PRIME, MOD_PRIME, MOD_PRIME, MOD_PRIME,
    30'd2, 30'd2, 30'd2, 30'd2, 30'd2,
    MOD_MAX, MOD_MAX, MOD_MAX, MOD_MAX, MOD_MAX, MOD_MAX,
    FIB_44, FIB_44
  };
  localparam logic [W-1:0] DIR_VAL [DIRECTED_ITEMS] = '{
    30'd0, 30'd1, 30'd2, MOD_MAX, 30'd1000000006,
    30'd1000000007, 30'd1000000008, 30'd123456789, 30'h2AAAAAAA, 30'h15555555,
    30'd0, 30'd1, 30'd2, 30'd3, MOD_MAX,
    30'd0, 30'd3, 30'd21, 30'd1073741822, MOD_MAX, 30'd2,
    FIB_43, 30'd267914296
  };

  typedef struct packed {
    logic [W-1:0] value;
    logic [W-1:0] modulus;
    logic [W-1:0] inverse;
    logic [W-1:0] divisor;
  } inverse_entry_t;

  // Holds the current modulus and the inverses still owed by the block.
  class inverse_tracker;
    logic [W-1:0]   modulus;
    inverse_entry_t owed_q[$];
    int unsigned    mismatches;

    function new();
      modulus = MOD_PRIME;
      mismatches = 0;
    endfunction

    function void set_modulus(logic [W-1:0] m);
      modulus = m;
    endfunction

    function int pending();
      return owed_q.size();
    endfunction

    // Quotient-based extended Euclid on (value, modulus), tracking only the
    // coefficient of value, then reducing it into 0..modulus-1.
    function inverse_entry_t extgcd(logic [W-1:0] value);
      longint m, old_r, r, old_s, s, q, t;
      inverse_entry_t e;
      m = modulus;
      old_r = value;
      r = m;
      old_s = 1;
      s = 0;
      while (r != 0) begin
        q = old_r / r;
        t = old_r - q * r;
        old_r = r;
        r = t;
        t = old_s - q * s;
        old_s = s;
        s = t;
      end
      if (m == 0) begin
        t = 0;
      end else if (old_s < 0) begin
        t = (-old_s) % m;
        if (t != 0) t = m - t;
      end else begin
        t = old_s % m;
      end
      e.value = value;
      e.modulus = modulus;
      e.inverse = W'(t);
      e.divisor = W'(old_r);
      return e;
    endfunction

    function void note_value(logic [W-1:0] value);
      owed_q.push_back(extgcd(value));
    endfunction

    function void check_result(logic [W-1:0] inverse, logic [W-1:0] divisor);
      inverse_entry_t want;
      if (owed_q.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("unexpected result transfer: inverse %0d, gcd %0d", inverse, divisor);
        return;
      end
      want = owed_q.pop_front();
      if (inverse !== want.inverse || divisor !== want.divisor) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("value %0d mod %0d: expected inverse %0d gcd %0d, got inverse %0d gcd %0d",
                   want.value, want.modulus, want.inverse, want.divisor, inverse, divisor);
      end
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [W-1:0]        cfg_data = '0;
  logic                in_tvalid = 1'b0;
  logic                in_tready;
  logic [IN_BITS-1:0]  in_tdata = '0;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [OUT_BITS-1:0] out_tdata;

  inverse_tracker tracker;
  int unsigned    in_idle_pct = 9;
  int unsigned    out_idle_pct = 80;
  int unsigned    quiet_cycles = 0;

  modular_inverse_extgcd #(.WIDTH(W)) uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),    // value
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)    // inverse, common_divisor
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Result side: random backpressure, and a check on every result transfer.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      tracker.check_result(out_tdata[W-1:0], out_tdata[2*W-1:W]);
    end
    out_tready <= ($urandom_range(99) >= out_idle_pct);
  end

  // Ends the run when no transfer of any kind has happened for too long.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("modular_inverse_extgcd_tb NOT OK");
        $finish;
      end
    end
  end

  // Offers one value, with random idle cycles first; valid stays high afterwards
  // so that back-to-back items need no extra edge.
  task automatic push_value(input logic [W-1:0] value);
    while ($urandom_range(99) < in_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= IN_BITS'(value);
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    tracker.note_value(value);
  endtask

  task automatic write_modulus(input logic [W-1:0] m);
    cfg_valid <= 1'b1;
    cfg_data  <= m;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    tracker.set_modulus(m);
  endtask

  // Stops offering values and waits until every owed result has been transferred.
  task automatic finish_phase();
    in_tvalid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
  endtask

  function automatic logic [W-1:0] pick_modulus(int unsigned phase);
    case (phase)
      0:       return MOD_PRIME;
      1, 7:    return W'($urandom_range(MOD_MAX, 1 << (W - 1)));
      2:       return W'($urandom_range(64, 2));
      3:       return W'($urandom_range(MOD_MAX / 2, 1)) << 1;
      4, 11:   return W'($urandom_range(32767, 2) * $urandom_range(32767, 2));
      5:       return FIB_44;
      6:       return MOD_MAX;
      8:       return W'($urandom_range(1000, 2));
      9:       return 30'd2;
      default: return W'($urandom_range(MOD_MAX, 2));
    endcase
  endfunction

  // Full-width values in four draws of ten; else small values, values below, at or above the
  // modulus, its multiples, edge values or multiples of six, which often share a factor with it.
  function automatic logic [W-1:0] random_value(logic [W-1:0] m);
    case ($urandom_range(9))
      0, 1, 2, 3: return W'($urandom);
      4:          return W'($urandom_range(1000));
      5:          return W'($urandom_range(m - 1, 1));
      6:          return (m > MOD_MAX - 1000) ? m : m + W'($urandom_range(1000));
      7:          return (m > MOD_MAX / 2) ? MOD_MAX - W'($urandom_range(3))
                                           : m * W'($urandom_range(MOD_MAX / m, 2));
      8:          return W'($urandom_range(1000, 1) * 6);
      default: begin
        case ($urandom_range(3))
          0:       return '0;
          1:       return 30'd1;
          2:       return MOD_MAX;
          default: return m - 1;
        endcase
      end
    endcase
  endfunction

  initial begin
    tracker = new();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part; the modulus is rewritten only when the group changes.
    foreach (DIR_VAL[i]) begin
      if (DIR_MOD[i] != tracker.modulus) begin
        finish_phase();
        write_modulus(DIR_MOD[i]);
      end
      push_value(DIR_VAL[i]);
    end

    // Random part: a fresh modulus per phase, idling pattern swapped by thirds.
    for (int unsigned phase = 0; phase < RANDOM_PHASES; phase++) begin
      finish_phase();
      if (phase == RANDOM_PHASES / 3) begin
        in_idle_pct = 80;
        out_idle_pct = 9;
      end else if (phase == 2 * RANDOM_PHASES / 3) begin
        in_idle_pct = 0;
        out_idle_pct = 0;
      end
      write_modulus(pick_modulus(phase));
      repeat (ITEMS_PER_PHASE) push_value(random_value(tracker.modulus));
    end

    finish_phase();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (tracker.mismatches == 0 && tracker.pending() == 0) begin
      $display("modular_inverse_extgcd_tb OK");
    end else begin
      $display("modular_inverse_extgcd_tb NOT OK");
    end
    $finish;
  end

endmodule
